/* rtl/core/spr_pkg.sv */
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants for the serpentine panel reorder block.
// ----------------------------------------------------------------------------
package spr_pkg;

   // panel dimension registers and coordinates inside the sequencer
   localparam int DIM_BITS   = 7;
   // strip position width, one quotient bit per divide step
   localparam int POS_BITS   = 12;
   localparam int DIV_STEPS  = POS_BITS;
   localparam int CNT_BITS   = 4;
   localparam int AREA_BITS  = 2 * DIM_BITS;
   localparam int COLOR_PORT = 24;
   localparam int COORD_PORT = 6;

   // item modes
   localparam logic MODE_STORE = 1'b0;
   localparam logic MODE_FETCH = 1'b1;

   // start corners
   localparam logic [1:0] CORNER_TOP_RIGHT    = 2'd0;
   localparam logic [1:0] CORNER_TOP_LEFT     = 2'd1;
   localparam logic [1:0] CORNER_BOTTOM_LEFT  = 2'd2;
   localparam logic [1:0] CORNER_BOTTOM_RIGHT = 2'd3;

   // register indexes (byte address 4*index)
   localparam logic [1:0] REG_PANEL_WIDTH   = 2'd0;
   localparam logic [1:0] REG_PANEL_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_START_CORNER  = 2'd2;
   localparam logic [1:0] REG_SCAN_VERTICAL = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MAP,
      ST_READ
   } state_type;

endpackage

/* rtl/core/spr_ram.sv */
// ----------------------------------------------------------------------------
// spr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module spr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/serpentine_panel_reorder.sv */
// ----------------------------------------------------------------------------
// serpentine_panel_reorder
// Frame store for a serpentine LED panel: stores pixels by column and row,
// fetches them by position along the strip.
// ----------------------------------------------------------------------------
//
//   channel   ports                          handshake
//   -------   ----------------------------   ---------------------------------
//   request   req_mode .. req_strip_position start high while busy low
//   result    rsp_pixel_color .. rsp_out_..  rsp_valid strobe, one cycle
//   config    psel penable pwrite paddr ...  apb, pready tied high
//
// A store is written to the frame RAM at the accept edge.
// A fetch runs 12 steps of the restoring divider (one quotient bit per
// step), then a mapping state that issues the RAM read and a read state
// for the registered read data; the result strobes in the next cycle.
// Out-of-range items answer in the cycle after accept. Reset is synchronous
// and clears control state only; the frame RAM holds garbage until written.
// The receiver cannot stall, so each result is shown for exactly one cycle.
//
module serpentine_panel_reorder
   import spr_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int COLOR_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_mode,
   input  logic [COORD_PORT-1:0] req_column,
   input  logic [COORD_PORT-1:0] req_row,
   input  logic [COLOR_PORT-1:0] req_color,
   input  logic [POS_BITS-1:0]   req_strip_position,
   // result channel
   output logic                  rsp_valid,
   output logic [COLOR_PORT-1:0] rsp_pixel_color,
   output logic [COORD_PORT-1:0] rsp_mapped_column,
   output logic [COORD_PORT-1:0] rsp_mapped_row,
   output logic                  rsp_out_of_range,
   // configuration port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [3:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // configuration registers
   logic [DIM_BITS-1:0] panel_width_ff;
   logic [DIM_BITS-1:0] panel_height_ff;
   logic [1:0]          start_corner_ff;
   logic                scan_vertical_ff;

   // sequencer and divider
   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [POS_BITS-1:0]   dvd_ff, dvd_in;
   logic [DIM_BITS-1:0]   rem_ff, rem_in;
   logic [DIM_BITS-1:0]   len_ff, len_in;
   logic [DIM_BITS-1:0]   col_ff, col_in;
   logic [DIM_BITS-1:0]   row_ff, row_in;

   // result registers
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COLOR_PORT-1:0] rsp_color_ff, rsp_color_in;
   logic [COORD_PORT-1:0] rsp_col_ff, rsp_col_in;
   logic [COORD_PORT-1:0] rsp_row_ff, rsp_row_in;
   logic                  rsp_oor_ff, rsp_oor_in;

   logic                  cfg_write;
   logic [DIM_BITS-1:0]   eff_w, eff_h;
   logic [AREA_BITS-1:0]  area;
   logic                  accept;
   logic                  store_oor, fetch_oor;
   logic [DIM_BITS+1:0]   trial;
   logic [DIM_BITS:0]     shifted;
   logic [DIM_BITS-1:0]   line, offs;
   logic                  top, right, par_odd;
   logic [DIM_BITS-1:0]   map_col, map_row;

   logic                  ram_we, ram_re;
   logic [AW-1:0]         ram_wr_addr, ram_rd_addr;
   logic [COLOR_BITS-1:0] ram_wr_data, ram_rd_data;
   logic [31:0]           rd_wide;

   // ---------------------------------------------------------------- config
   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_width_ff   <= DIM_BITS'(8);
         panel_height_ff  <= DIM_BITS'(8);
         start_corner_ff  <= CORNER_TOP_RIGHT;
         scan_vertical_ff <= 1'b0;
      end else if (cfg_write) begin
         unique case (paddr[3:2])
            REG_PANEL_WIDTH:   panel_width_ff   <= pwdata[DIM_BITS-1:0];
            REG_PANEL_HEIGHT:  panel_height_ff  <= pwdata[DIM_BITS-1:0];
            REG_START_CORNER:  start_corner_ff  <= pwdata[1:0];
            REG_SCAN_VERTICAL: scan_vertical_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_PANEL_WIDTH:   prdata = 32'(panel_width_ff);
         REG_PANEL_HEIGHT:  prdata = 32'(panel_height_ff);
         REG_START_CORNER:  prdata = 32'(start_corner_ff);
         REG_SCAN_VERTICAL: prdata = 32'(scan_vertical_ff);
         default:           prdata = '0;
      endcase
   end

   // saturate sizes to the store dimensions
   assign eff_w = (32'(panel_width_ff) > MAX_WIDTH) ? DIM_BITS'(MAX_WIDTH) : panel_width_ff;
   assign eff_h = (32'(panel_height_ff) > MAX_HEIGHT) ? DIM_BITS'(MAX_HEIGHT)
                                                      : panel_height_ff;
   assign area  = AREA_BITS'(eff_w) * AREA_BITS'(eff_h);

   // ---------------------------------------------------------------- checks
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start & ~busy;
   assign store_oor = (DIM_BITS'(req_column) >= eff_w) || (DIM_BITS'(req_row) >= eff_h);
   // zero size gives zero area, so every position is out of range
   assign fetch_oor = AREA_BITS'(req_strip_position) >= area;

   // ---------------------------------------------------------------- divider
   assign shifted = {rem_ff, dvd_ff[POS_BITS-1]};
   assign trial   = {1'b0, shifted} - {2'b00, len_ff};

   // ---------------------------------------------------------------- mapping
   assign line  = dvd_ff[DIM_BITS-1:0];
   assign offs  = rem_ff;
   assign top   = (start_corner_ff == CORNER_TOP_RIGHT) ||
                  (start_corner_ff == CORNER_TOP_LEFT);
   assign right = (start_corner_ff == CORNER_TOP_RIGHT) ||
                  (start_corner_ff == CORNER_BOTTOM_RIGHT);

   always_comb begin
      if (!scan_vertical_ff) begin
         // parity that sets the direction of the current line
         par_odd = top ? (eff_h[0] ^ line[0]) : line[0];
         map_row = top ? (eff_h - DIM_BITS'(1) - line) : line;
         if (right ^ par_odd) begin
            map_col = eff_w - DIM_BITS'(1) - offs;
         end else begin
            map_col = offs;
         end
      end else begin
         par_odd = right ? (eff_w[0] ^ line[0]) : line[0];
         map_col = right ? (eff_w - DIM_BITS'(1) - line) : line;
         if (top ^ par_odd) begin
            map_row = eff_h - DIM_BITS'(1) - offs;
         end else begin
            map_row = offs;
         end
      end
   end

   // ---------------------------------------------------------------- frame ram
   assign ram_wr_addr = AW'(32'(req_row) * MAX_WIDTH + 32'(req_column));
   assign ram_rd_addr = AW'(32'(map_row) * MAX_WIDTH + 32'(map_col));
   assign ram_wr_data = COLOR_BITS'(32'(req_color));
   assign rd_wide     = 32'(ram_rd_data);

   spr_ram #(
      .WIDTH (COLOR_BITS),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_frame (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------- sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      len_ff       <= len_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      rsp_color_ff <= rsp_color_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      len_in       = len_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      rsp_valid_in = 1'b0;
      rsp_color_in = rsp_color_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_oor_in   = rsp_oor_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if ((req_mode == MODE_STORE) ? store_oor : fetch_oor) begin
                  rsp_valid_in = 1'b1;
                  rsp_color_in = '0;
                  rsp_col_in   = '0;
                  rsp_row_in   = '0;
                  rsp_oor_in   = 1'b1;
               end else if (req_mode == MODE_STORE) begin
                  ram_we = 1'b1;
               end else begin
                  dvd_in   = req_strip_position;
                  rem_in   = '0;
                  cnt_in   = '0;
                  len_in   = scan_vertical_ff ? eff_h : eff_w;
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            // restoring step: keep the difference when it did not borrow
            dvd_in = {dvd_ff[POS_BITS-2:0], ~trial[DIM_BITS+1]};
            rem_in = trial[DIM_BITS+1] ? shifted[DIM_BITS-1:0] : trial[DIM_BITS-1:0];
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(DIV_STEPS - 1)) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            col_in   = map_col;
            row_in   = map_row;
            ram_re   = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_color_in = rd_wide[COLOR_PORT-1:0];
            rsp_col_in   = col_ff[COORD_PORT-1:0];
            rsp_row_in   = row_ff[COORD_PORT-1:0];
            rsp_oor_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_color   = rsp_color_ff;
   assign rsp_mapped_column = rsp_col_ff;
   assign rsp_mapped_row    = rsp_row_ff;
   assign rsp_out_of_range  = rsp_oor_ff;

   // ---------------------------------------------------------------- assertions
   // no result can appear while the divider is stepping
   a_no_rsp_in_divide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> !rsp_valid)
      else $error("result strobe during divide");

   // an in-range store is silent
   a_store_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_STORE && !store_oor) |=> !rsp_valid)
      else $error("in-range store produced a result");

   // remainder stays below the line length after the last step
   a_rem_below_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAP) |-> (rem_ff < len_ff))
      else $error("divider remainder not below line length");

   // a mapped fetch lands inside the panel
   a_map_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (col_ff < eff_w && row_ff < eff_h))
      else $error("mapped location outside panel");

endmodule

/* test/serpentine_panel_reorder_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serpentine_panel_reorder_test
// Drives stores and strip fetches into the panel reorder block over a range of
// panel sizes, start corners and scan directions. A local mirror of the frame
// and of the registers predicts every result, which is checked field by field.
// ----------------------------------------------------------------------------
module serpentine_panel_reorder_test;
   import spr_pkg::*;

   localparam int PANEL_MAX    = 64;
   localparam int PHASE_COUNT  = 24;
   localparam int PHASE_ITEMS  = 64;
   localparam int SETTLE_PAD   = 24;

   typedef struct packed {
      logic                  mode;
      logic [COORD_PORT-1:0] column;
      logic [COORD_PORT-1:0] row;
      logic [COLOR_PORT-1:0] color;
      logic [POS_BITS-1:0]   strip_position;
   } panel_item_type;

   typedef struct packed {
      logic [COLOR_PORT-1:0] pixel_color;
      logic [COORD_PORT-1:0] mapped_column;
      logic [COORD_PORT-1:0] mapped_row;
      logic                  out_of_range;
   } pixel_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_mode = MODE_STORE;
   logic [COORD_PORT-1:0] req_column = '0;
   logic [COORD_PORT-1:0] req_row = '0;
   logic [COLOR_PORT-1:0] req_color = '0;
   logic [POS_BITS-1:0]   req_strip_position = '0;
   logic                  rsp_valid;
   logic [COLOR_PORT-1:0] rsp_pixel_color;
   logic [COORD_PORT-1:0] rsp_mapped_column;
   logic [COORD_PORT-1:0] rsp_mapped_row;
   logic                  rsp_out_of_range;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [3:0]            paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   // register mirror, shared by the item builder and the predictor
   logic [DIM_BITS-1:0]   cfg_width = 7'd8;
   logic [DIM_BITS-1:0]   cfg_height = 7'd8;
   logic [1:0]            cfg_corner = CORNER_TOP_RIGHT;
   logic                  cfg_vertical = 1'b0;

   logic [COLOR_PORT-1:0] frame_mirror [0:PANEL_MAX*PANEL_MAX-1];
   bit                    built_written [0:PANEL_MAX*PANEL_MAX-1];

   panel_item_type        pending_items [$];
   pixel_result_type      pixel_expect [$];
   panel_item_type        drive_item;
   int                    gap_left = 0;
   bit                    sender_calm = 1'b1;
   int                    phase_count = 0;
   int                    mismatch_count = 0;

   serpentine_panel_reorder dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_column         (req_column),
      .req_row            (req_row),
      .req_color          (req_color),
      .req_strip_position (req_strip_position),
      .rsp_valid          (rsp_valid),
      .rsp_pixel_color    (rsp_pixel_color),
      .rsp_mapped_column  (rsp_mapped_column),
      .rsp_mapped_row     (rsp_mapped_row),
      .rsp_out_of_range   (rsp_out_of_range),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic int eff_dim(input logic [DIM_BITS-1:0] v);
      return (v > PANEL_MAX) ? PANEL_MAX : int'(v);
   endfunction

   // strip position to panel column and row under the current registers
   function automatic void map_position(input int pos, output int col, output int row);
      int  w;
      int  h;
      int  line;
      int  k;
      int  par;
      bit  top;
      bit  right;
      w = eff_dim(cfg_width);
      h = eff_dim(cfg_height);
      line = pos / (cfg_vertical ? h : w);
      k = pos % (cfg_vertical ? h : w);
      top = (cfg_corner == CORNER_TOP_RIGHT) || (cfg_corner == CORNER_TOP_LEFT);
      right = (cfg_corner == CORNER_TOP_RIGHT) || (cfg_corner == CORNER_BOTTOM_RIGHT);
      if (!cfg_vertical) begin
         par = top ? (h - line) : line;
         row = top ? (h - 1 - line) : line;
         col = (((par % 2) == 0) == right) ? (w - 1 - k) : k;
      end else begin
         par = right ? (w - line) : line;
         col = right ? (w - 1 - line) : line;
         row = (((par % 2) == 0) == top) ? (h - 1 - k) : k;
      end
   endfunction

   function automatic void note_mismatch(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
      if (mismatch_count < 10)
         $display("%s mismatch: expected %0h got %0h", what, want, got);
      mismatch_count++;
   endfunction

   function automatic void predict_panel_item(input panel_item_type it);
      pixel_result_type res;
      int               w;
      int               h;
      int               c;
      int               r;
      w = eff_dim(cfg_width);
      h = eff_dim(cfg_height);
      res = '0;
      if (it.mode == MODE_STORE) begin
         if (it.column >= w || it.row >= h) begin
            res.out_of_range = 1'b1;
            pixel_expect.push_back(res);
         end else begin
            frame_mirror[it.row * PANEL_MAX + it.column] = it.color;
         end
      end else if (w == 0 || h == 0 || it.strip_position >= w * h) begin
         res.out_of_range = 1'b1;
         pixel_expect.push_back(res);
      end else begin
         map_position(int'(it.strip_position), c, r);
         res.pixel_color = frame_mirror[r * PANEL_MAX + c];
         res.mapped_column = COORD_PORT'(c);
         res.mapped_row = COORD_PORT'(r);
         pixel_expect.push_back(res);
      end
   endfunction

   function automatic panel_item_type random_item();
      panel_item_type it;
      it.mode = MODE_STORE;
      it.column = COORD_PORT'($urandom());
      it.row = COORD_PORT'($urandom());
      it.color = COLOR_PORT'($urandom());
      it.strip_position = POS_BITS'($urandom());
      return it;
   endfunction

   function automatic void push_store(input int col, input int row,
                                      input logic [COLOR_PORT-1:0] color);
      panel_item_type it;
      it = random_item();
      it.mode = MODE_STORE;
      it.column = COORD_PORT'(col);
      it.row = COORD_PORT'(row);
      it.color = color;
      if (col < eff_dim(cfg_width) && row < eff_dim(cfg_height))
         built_written[row * PANEL_MAX + col] = 1'b1;
      pending_items.push_back(it);
      phase_count++;
   endfunction

   // a fetch of a pixel never written is preceded by a store to that pixel
   function automatic void push_fetch(input int pos);
      panel_item_type it;
      int             c;
      int             r;
      if (pos < eff_dim(cfg_width) * eff_dim(cfg_height)) begin
         map_position(pos, c, r);
         if (!built_written[r * PANEL_MAX + c])
            push_store(c, r, COLOR_PORT'($urandom()));
      end
      it = random_item();
      it.mode = MODE_FETCH;
      it.strip_position = POS_BITS'(pos);
      pending_items.push_back(it);
      phase_count++;
   endfunction

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] want;
      logic [31:0] got;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_PANEL_WIDTH: begin
            cfg_width = value[DIM_BITS-1:0];
            want = 32'(cfg_width);
         end
         REG_PANEL_HEIGHT: begin
            cfg_height = value[DIM_BITS-1:0];
            want = 32'(cfg_height);
         end
         REG_START_CORNER: begin
            cfg_corner = value[1:0];
            want = 32'(cfg_corner);
         end
         default: begin
            cfg_vertical = value[0];
            want = 32'(cfg_vertical);
         end
      endcase
      // read the register back
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      got = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if (got !== want)
         note_mismatch("register readback", want, got);
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || start || pixel_expect.size() != 0)
         @(posedge clock);
      repeat (SETTLE_PAD) @(posedge clock);
   endtask

   // sender: one item in flight, random gap before each launch unless sender_calm is set
   always @(posedge clock) begin : item_sender
      logic next_start;
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            predict_panel_item(drive_item);
            next_start = 1'b0;
         end
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() > 0) begin
               drive_item = pending_items.pop_front();
               req_mode <= drive_item.mode;
               req_column <= drive_item.column;
               req_row <= drive_item.row;
               req_color <= drive_item.color;
               req_strip_position <= drive_item.strip_position;
               next_start = 1'b1;
               gap_left = (sender_calm || $urandom_range(0, 1) == 0) ? 0 :
                          int'($urandom_range(0, 15));
            end
         end
         start <= next_start;
      end
   end

   always @(posedge clock) begin : result_monitor
      pixel_result_type want;
      if (!reset && rsp_valid) begin
         if (pixel_expect.size() == 0) begin
            note_mismatch("unexpected result", 32'(0), 32'(rsp_out_of_range));
         end else begin
            want = pixel_expect.pop_front();
            if (rsp_pixel_color !== want.pixel_color)
               note_mismatch("pixel_color", 32'(want.pixel_color),
                             32'(rsp_pixel_color));
            if (rsp_mapped_column !== want.mapped_column)
               note_mismatch("mapped_column", 32'(want.mapped_column),
                             32'(rsp_mapped_column));
            if (rsp_mapped_row !== want.mapped_row)
               note_mismatch("mapped_row", 32'(want.mapped_row),
                             32'(rsp_mapped_row));
            if (rsp_out_of_range !== want.out_of_range)
               note_mismatch("out_of_range", 32'(want.out_of_range),
                             32'(rsp_out_of_range));
         end
      end
   end

   initial begin : stimulus
      logic [1:0] corner_cycle [0:3];
      int         w;
      int         h;
      int         pick;
      corner_cycle[0] = CORNER_TOP_RIGHT;
      corner_cycle[1] = CORNER_TOP_LEFT;
      corner_cycle[2] = CORNER_BOTTOM_LEFT;
      corner_cycle[3] = CORNER_BOTTOM_RIGHT;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed items at the reset setting: 8x8, top-right, horizontal
      push_store(0, 0, 24'h000000);
      push_store(7, 7, 24'hFFFFFF);
      push_store(3, 5, 24'hA5A5A5);
      push_store(8, 0, 24'h123456);
      push_store(0, 8, 24'h654321);
      push_store(63, 63, 24'hFFFFFF);
      push_fetch(0);
      push_fetch(7);
      push_fetch(8);
      push_fetch(15);
      push_fetch(56);
      push_fetch(63);
      push_fetch(64);
      push_fetch(4095);
      wait_drained();

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0: begin w = 64; h = 64; end
            1: begin w = 1; h = 1; end
            2: begin w = 1; h = 64; end
            3: begin w = 64; h = 1; end
            4: begin w = 0; h = 8; end
            5: begin w = 8; h = 0; end
            6: begin w = 127; h = 100; end
            7: begin w = 65; h = 3; end
            default: begin
               w = $urandom_range(1, (ph % 3 == 0) ? 64 : 12);
               h = $urandom_range(1, (ph % 3 == 0) ? 64 : 12);
            end
         endcase
         write_reg(REG_PANEL_WIDTH, 32'(w));
         write_reg(REG_PANEL_HEIGHT, 32'(h));
         write_reg(REG_START_CORNER, 32'(corner_cycle[ph % 4]));
         write_reg(REG_SCAN_VERTICAL, 32'((ph / 4) % 2));
         sender_calm = (ph % 3 == 1);
         w = eff_dim(cfg_width);
         h = eff_dim(cfg_height);
         phase_count = 0;
         while (phase_count < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 30 && w > 0 && h > 0)
               push_store($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                          COLOR_PORT'($urandom()));
            else if (pick < 40)
               push_store($urandom_range(0, 63), $urandom_range(0, 63),
                          COLOR_PORT'($urandom()));
            else if (pick < 85 && w * h > 0)
               push_fetch($urandom_range(0, w * h - 1));
            else
               push_fetch($urandom_range(0, 4095));
         end
         wait_drained();
      end

      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/spr_pkg.sv
rtl/core/spr_ram.sv
rtl/core/serpentine_panel_reorder.sv
test/serpentine_panel_reorder_test.sv
